// ===== rtl/gsr_pkg.sv =====
package gsr_pkg;

  localparam int GRAINS     = 10;
  localparam int GRAIN_MAX  = 8192;
  localparam int MAX_TAPS   = 128;
  localparam int CANVAS_LEN = 16384;

  localparam int SLOT_W   = 4;
  localparam int POS_W    = 13;
  localparam int LEN_W    = 14;
  localparam int TAP_W    = 7;
  localparam int CPOS_W   = 14;
  localparam int CELL_W   = 24;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int DELAY_W  = 14;

  localparam int GRAIN_ENTRIES = GRAINS * GRAIN_MAX;
  localparam int TAP_ENTRIES   = GRAINS * MAX_TAPS;
  localparam int GADDR_W       = SLOT_W + POS_W;
  localparam int TADDR_W       = SLOT_W + TAP_W;
  localparam int TWORD_W       = DELAY_W + GAIN_W;

  localparam logic [LEN_W-1:0] RESET_LENGTH = 14'd4410;
  localparam logic [LEN_W-1:0] LEN_MAX      = 14'd8192;
  localparam logic [7:0]       TAPS_MAX     = 8'd128;
  localparam logic [SLOT_W-1:0] LAST_SLOT   = 4'd9;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_WIN, S_WMUL, S_GRD, S_GWAIT,
    S_TRD, S_TWR, S_CRD, S_CMUL, S_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

  // quarter-wave sine, Q15
  function automatic logic [15:0] sine_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3212;
      5'd2:    v = 16'd6393;
      5'd3:    v = 16'd9512;
      5'd4:    v = 16'd12540;
      5'd5:    v = 16'd15447;
      5'd6:    v = 16'd18205;
      5'd7:    v = 16'd20788;
      5'd8:    v = 16'd23170;
      5'd9:    v = 16'd25330;
      5'd10:   v = 16'd27246;
      5'd11:   v = 16'd28899;
      5'd12:   v = 16'd30274;
      5'd13:   v = 16'd31357;
      5'd14:   v = 16'd32138;
      5'd15:   v = 16'd32610;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  // Hann weight in Q16, 0..65536
  function automatic logic signed [17:0] hann(input logic [15:0] p);
    logic [14:0]        arg;
    logic [4:0]         i;
    logic [15:0]        lo;
    logic [15:0]        hi;
    logic [25:0]        prod;
    logic [15:0]        s;
    logic signed [17:0] c;
    arg = p[14] ? {1'b0, p[13:0]} : (15'd16384 - {1'b0, p[13:0]});
    i   = arg[14:10];
    lo  = sine_tab(i);
    hi  = sine_tab(i + 5'd1);
    prod = (hi - lo) * arg[9:0];
    s   = arg[14] ? 16'd32768 : (lo + prod[25:10]);
    c   = (p[15] ^ p[14]) ? -$signed({2'b00, s}) : $signed({2'b00, s});
    return 18'sd32768 - c;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    logic signed [15:0] r;
    if (v > 26'sd32767) r = 16'sh7fff;
    else if (v < -26'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) r = 24'sh7fffff;
    else if (v < -26'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ===== rtl/gsr_ram.sv =====
module gsr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== rtl/gsr_div.sv =====
module gsr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gsr_pkg::div_req_t   req_i,
  output gsr_pkg::div_rsp_t   rsp_o
);
  import gsr_pkg::*;

  logic [LEN_W-1:0] rem_q, rem_d, len_q;
  logic [15:0]      quo_q;
  logic [3:0]       cnt_q;
  logic             busy_q, done_q;
  logic [LEN_W:0]   dbl;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign dbl   = {rem_q, 1'b0};
  assign ge    = dbl >= {1'b0, len_q};
  assign rem_d = ge ? LEN_W'(dbl - {1'b0, len_q}) : dbl[LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.pos};
      len_q <= req_i.len;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[14:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
endmodule

// ===== rtl/granular_scatter_reverb_top.sv =====
// Granular scatter reverb.
// Input stream (s_axis_*): one beat per item. tuser = op: 0 audio sample, 1 tap table
// load. Load beats write one delay/gain entry and give no result. Audio beats give one
// output beat (m_axis_*) carrying the left and right samples.
// An audio beat passes from acceptance to the output register through the Hann phase
// divider, window and grain store access, then a canvas read-modify-write per tap on
// the single canvas port pair, then the output and feedback multiply; while frozen the
// divider and window are skipped. Items are taken one at a time.
// The finished result sits in an output register; a stalled receiver holds it there
// while the next input beat is taken and worked on, and the block only waits for the
// register to drain when the next result is ready.
// Reset: positions, lengths and freeze go to their reset values, then a clearing pass
// zeroes the grain store and both canvases, one entry a cycle, during which s_axis_tready
// stays low. Tap tables are not cleared: load every tap entry in use before the first
// audio beat.
module granular_scatter_reverb_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // in_sample, amplitude, grain_length, feedback_gain, tap_count, freeze_request,
  // table_channel, table_grain, table_tap, table_delay, table_gain
  input  logic [111:0] s_axis_tdata,
  // op
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_left, out_right
  output logic [31:0]  m_axis_tdata
);
  import gsr_pkg::*;

  state_e state_q, state_d;

  // input beat fields
  logic signed [15:0] in_sample;
  logic [15:0]        in_amp;
  logic [13:0]        in_len;
  logic [14:0]        in_fb;
  logic [7:0]         in_taps;
  logic               in_freeze, in_chan;
  logic [3:0]         in_grain;
  logic [6:0]         in_tap;
  logic [13:0]        in_delay;
  logic [15:0]        in_gain;

  assign in_sample = s_axis_tdata[15:0];
  assign in_amp    = s_axis_tdata[31:16];
  assign in_len    = s_axis_tdata[45:32];
  assign in_fb     = s_axis_tdata[60:46];
  assign in_taps   = s_axis_tdata[68:61];
  assign in_freeze = s_axis_tdata[69];
  assign in_chan   = s_axis_tdata[70];
  assign in_grain  = s_axis_tdata[74:71];
  assign in_tap    = s_axis_tdata[81:75];
  assign in_delay  = s_axis_tdata[95:82];
  assign in_gain   = s_axis_tdata[111:96];

  logic accept, audio_acc, load_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign audio_acc = accept && !s_axis_tuser;
  assign load_acc  = accept && s_axis_tuser;

  // position state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CPOS_W-1:0] cpos_q;
  logic [LEN_W-1:0]  alen_q, len_clamp, len_eff, pos_inc;
  logic              frozen_q, frozen_d, bnd;

  assign len_clamp = (in_len == '0) ? LEN_W'(1) : ((in_len > LEN_MAX) ? LEN_MAX : in_len);
  assign len_eff   = frozen_q ? alen_q : len_clamp;
  assign pos_inc   = {1'b0, pos_q} + LEN_W'(1);
  assign bnd       = pos_inc >= len_eff;
  assign pos_d     = bnd ? '0 : pos_inc[POS_W-1:0];
  assign slot_d    = bnd ? ((slot_q == LAST_SLOT) ? '0 : slot_q + 4'd1) : slot_q;
  assign frozen_d  = bnd ? in_freeze : frozen_q;

  // per-item operands
  logic signed [15:0] sample_q, g_q;
  logic [15:0]        amp_q;
  logic [14:0]        fb_q;
  logic [7:0]         taps_q, tap_i_q;
  logic signed [17:0] w_q;
  logic signed [16:0] al_q, ar_q;
  logic [CPOS_W-1:0]  cal_q, car_q;
  logic signed [41:0] pol_q, por_q;
  logic signed [39:0] pfl_q, pfr_q;
  logic [31:0]        out_q;
  logic               out_valid_q, out_free;
  logic [GADDR_W-1:0] clr_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Hann phase divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  assign div_req.start = audio_acc && !frozen_d;
  assign div_req.pos   = pos_d;
  assign div_req.len   = len_eff;

  gsr_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // memories
  logic               g_we, g_re;
  logic [GADDR_W-1:0] g_waddr, g_raddr;
  logic [15:0]        g_wdata, g_rdata;
  logic               tl_we, tr_we, t_re;
  logic [TADDR_W-1:0] t_waddr, t_raddr;
  logic [TWORD_W-1:0] t_wdata, tl_rdata, tr_rdata;
  logic               c_we, c_re;
  logic [CPOS_W-1:0]  cl_waddr, cr_waddr, cl_raddr, cr_raddr;
  logic [CELL_W-1:0]  cl_wdata, cr_wdata, cl_rdata, cr_rdata;

  gsr_ram #(.DEPTH(GRAIN_ENTRIES), .WIDTH(SAMPLE_W)) u_grain (
    .clk_i(clk_i), .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .re_i(g_re), .raddr_i(g_raddr), .rdata_o(g_rdata)
  );
  gsr_ram #(.DEPTH(TAP_ENTRIES), .WIDTH(TWORD_W)) u_tap_l (
    .clk_i(clk_i), .we_i(tl_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(tl_rdata)
  );
  gsr_ram #(.DEPTH(TAP_ENTRIES), .WIDTH(TWORD_W)) u_tap_r (
    .clk_i(clk_i), .we_i(tr_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(tr_rdata)
  );
  gsr_ram #(.DEPTH(CANVAS_LEN), .WIDTH(CELL_W)) u_canvas_l (
    .clk_i(clk_i), .we_i(c_we), .waddr_i(cl_waddr), .wdata_i(cl_wdata),
    .re_i(c_re), .raddr_i(cl_raddr), .rdata_o(cl_rdata)
  );
  gsr_ram #(.DEPTH(CANVAS_LEN), .WIDTH(CELL_W)) u_canvas_r (
    .clk_i(clk_i), .we_i(c_we), .waddr_i(cr_waddr), .wdata_i(cr_wdata),
    .re_i(c_re), .raddr_i(cr_raddr), .rdata_o(cr_rdata)
  );

  // datapath terms
  logic signed [33:0] wprod;
  logic signed [32:0] tpl, tpr;
  logic signed [25:0] tsl, tsr;
  logic signed [24:0] dsl, dsr;
  logic signed [15:0] dry;
  logic [7:0]         tap_nx;

  assign wprod  = w_q * sample_q;
  assign tpl    = $signed({1'b0, tl_rdata[TWORD_W-1:DELAY_W]}) * g_q;
  assign tpr    = $signed({1'b0, tr_rdata[TWORD_W-1:DELAY_W]}) * g_q;
  assign tsl    = $signed(cl_rdata) + al_q;
  assign tsr    = $signed(cr_rdata) + ar_q;
  assign dry    = frozen_q ? 16'sd0 : sample_q;
  assign dsl    = $signed(cl_rdata) + dry;
  assign dsr    = $signed(cr_rdata) + dry;
  assign tap_nx = tap_i_q + 8'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == GADDR_W'(GRAIN_ENTRIES - 1)) state_d = S_IDLE;
      S_IDLE:  if (audio_acc) state_d = frozen_d ? S_GRD : S_DIV;
      S_DIV:   if (div_rsp.done) state_d = S_WIN;
      S_WIN:   state_d = S_WMUL;
      S_WMUL:  state_d = S_GRD;
      S_GRD:   state_d = S_GWAIT;
      S_GWAIT: state_d = (taps_q == '0) ? S_CRD : S_TRD;
      S_TRD:   state_d = S_TWR;
      S_TWR:   state_d = (tap_i_q == taps_q) ? S_CRD : S_TRD;
      S_CRD:   state_d = S_CMUL;
      S_CMUL:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    g_we     = 1'b0;
    g_waddr  = {slot_q, pos_q};
    g_wdata  = sat16(26'($signed(wprod[33:16])));
    g_re     = 1'b0;
    g_raddr  = {slot_q, pos_q};
    tl_we    = load_acc && !in_chan && (in_grain < SLOT_W'(GRAINS));
    tr_we    = load_acc && in_chan && (in_grain < SLOT_W'(GRAINS));
    t_waddr  = {in_grain, in_tap};
    t_wdata  = {in_gain, in_delay};
    t_re     = 1'b0;
    t_raddr  = {slot_q, TAP_W'(0)};
    c_we     = 1'b0;
    c_re     = 1'b0;
    cl_waddr = cal_q;
    cr_waddr = car_q;
    cl_wdata = sat24(26'(tsl));
    cr_wdata = sat24(26'(tsr));
    cl_raddr = cpos_q;
    cr_raddr = cpos_q;
    case (state_q)
      S_CLEAR: begin
        g_we     = 1'b1;
        g_waddr  = clr_q;
        g_wdata  = '0;
        c_we     = 1'b1;
        cl_waddr = clr_q[CPOS_W-1:0];
        cr_waddr = clr_q[CPOS_W-1:0];
        cl_wdata = '0;
        cr_wdata = '0;
      end
      S_WMUL:  g_we = 1'b1;
      S_GRD:   g_re = 1'b1;
      S_GWAIT: t_re = 1'b1;
      S_TRD: begin
        t_re     = 1'b1;
        t_raddr  = {slot_q, tap_nx[TAP_W-1:0]};
        c_re     = 1'b1;
        cl_raddr = cpos_q + tl_rdata[DELAY_W-1:0];
        cr_raddr = cpos_q + tr_rdata[DELAY_W-1:0];
      end
      S_TWR:   c_we = 1'b1;
      S_CRD:   c_re = 1'b1;
      S_OUT: begin
        c_we     = out_free;
        cl_waddr = cpos_q;
        cr_waddr = cpos_q;
        cl_wdata = sat24(pfl_q[39:14]);
        cr_wdata = sat24(pfr_q[39:14]);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      slot_q      <= '0;
      cpos_q      <= '1;
      alen_q      <= RESET_LENGTH;
      frozen_q    <= 1'b0;
      out_valid_q <= 1'b0;
      tap_i_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + GADDR_W'(1);
      if (audio_acc) begin
        alen_q   <= len_eff;
        pos_q    <= pos_d;
        slot_q   <= slot_d;
        frozen_q <= frozen_d;
        cpos_q   <= cpos_q + CPOS_W'(1);
      end
      if (state_q == S_GWAIT) tap_i_q <= '0;
      if (state_q == S_TRD) tap_i_q <= tap_nx;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (audio_acc) begin
      sample_q <= in_sample;
      amp_q    <= in_amp;
      fb_q     <= in_fb;
      taps_q   <= (in_taps > TAPS_MAX) ? TAPS_MAX : in_taps;
    end
    if (state_q == S_WIN) w_q <= hann(div_rsp.quot);
    if (state_q == S_GWAIT) g_q <= g_rdata;
    if (state_q == S_TRD) begin
      al_q  <= tpl[32:16];
      ar_q  <= tpr[32:16];
      cal_q <= cl_raddr;
      car_q <= cr_raddr;
    end
    if (state_q == S_CMUL) begin
      pol_q <= dsl * $signed({1'b0, amp_q});
      por_q <= dsr * $signed({1'b0, amp_q});
      pfl_q <= $signed(cl_rdata) * $signed({1'b0, fb_q});
      pfr_q <= $signed(cr_rdata) * $signed({1'b0, fb_q});
    end
    if (state_q == S_OUT && out_free) begin
      out_q[15:0]  <= sat16(pol_q[41:16]);
      out_q[31:16] <= sat16(por_q[41:16]);
    end
  end
endmodule
